// ----- hw/rtl/ampq_pkg.sv -----
// shared types and constants for the array min priority queue
// no dependencies
`timescale 1ns / 1ps

package ampq_pkg;

  localparam int DEPTH = 16;
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  localparam int KEY_W = 32;
  localparam int TAG_W = 16;
  localparam int OCC_W = 5;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
  } entry_t;

endpackage

// ----- hw/rtl/array_min_priority_queue.sv -----
// top level of the array min priority queue: entry memory and sequencer
// depends on ampq_pkg
`timescale 1ns / 1ps

// usage
//   command channel: an item (kind, key, tag) is taken at a rising edge with
//   start high and busy low. kind push appends the entry, kind pop removes the
//   entry with the smallest signed key, the oldest one on a tie.
//   result channel: done is high for exactly one cycle and carries out_key,
//   out_tag, status and occupancy (entries held after the item). out_key and
//   out_tag are zero for every push and for a pop on an empty queue.
//   the receiver cannot stall; a result must be taken in its done cycle.
// pop sequence, with n entries held when a pop is taken
//   push, or pop on empty: done follows in the next cycle
//   pop: one memory read per cycle scans all n entries, then one
//   read plus write per cycle moves the later entries down; nothing is
//   moved when the minimum is the last entry.
// throughput: a new item can be taken in the cycle done is high
// reset: the queue is empty; memory contents are not cleared

module array_min_priority_queue (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              kind,
  input  logic signed [ampq_pkg::KEY_W-1:0] key,
  input  logic [ampq_pkg::TAG_W-1:0]        tag,
  output logic                              done,
  output logic signed [ampq_pkg::KEY_W-1:0] out_key,
  output logic [ampq_pkg::TAG_W-1:0]        out_tag,
  output logic [1:0]                        status,
  output logic [ampq_pkg::OCC_W-1:0]        occupancy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_PRE,
    S_SHIFT
  } state_t;

  state_t state;

  // entry memory, one write and one registered read per cycle
  ampq_pkg::entry_t mem [ampq_pkg::DEPTH];
  ampq_pkg::entry_t rd_data;
  logic [ampq_pkg::IW-1:0] rd_addr;
  logic [ampq_pkg::IW-1:0] wr_addr;
  ampq_pkg::entry_t wr_data;
  logic mem_we;

  // sequencer registers
  logic [ampq_pkg::CW-1:0] count;     // entries held
  logic [ampq_pkg::CW-1:0] ptr;       // next scan read address
  logic [ampq_pkg::CW-1:0] cmp_idx;   // position of rd_data during the scan
  logic [ampq_pkg::CW-1:0] mv_idx;    // destination of the current move
  logic [ampq_pkg::CW-1:0] best_idx;
  ampq_pkg::entry_t        best;
  logic                    have_best;

  logic                    accept;
  logic                    take_new;
  logic                    scan_last;
  logic [ampq_pkg::CW-1:0] best_idx_cur;
  ampq_pkg::entry_t        best_cur;
  logic [ampq_pkg::CW-1:0] count_m1;

  assign accept   = start && !busy;
  assign busy     = (state != S_IDLE);
  assign count_m1 = ampq_pkg::CW'(count - 1'b1);

  // the shared compare: current memory word against the best so far
  assign take_new     = !have_best || (rd_data.key < best.key);
  assign best_cur     = take_new ? rd_data : best;
  assign best_idx_cur = take_new ? cmp_idx : best_idx;
  assign scan_last    = (cmp_idx == count_m1);

  // memory address and write selection
  always_comb begin
    rd_addr = '0;
    wr_addr = count[ampq_pkg::IW-1:0];
    wr_data = '{key: key, tag: tag};
    mem_we  = 1'b0;
    unique case (state)
      S_IDLE: begin
        // first scan read goes out while idle
        rd_addr = '0;
        mem_we  = accept && (kind == ampq_pkg::KIND_PUSH) &&
                  (count < ampq_pkg::CW'(ampq_pkg::DEPTH));
      end
      S_SCAN: begin
        rd_addr = ptr[ampq_pkg::IW-1:0];
      end
      S_SHIFT_PRE: begin
        rd_addr = ampq_pkg::IW'(best_idx + 1'b1);
      end
      S_SHIFT: begin
        rd_addr = ampq_pkg::IW'(mv_idx + 2'd2);
        wr_addr = mv_idx[ampq_pkg::IW-1:0];
        wr_data = rd_data;
        mem_we  = 1'b1;
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      done      <= 1'b0;
      have_best <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (kind == ampq_pkg::KIND_PUSH) begin
              done    <= 1'b1;
              out_key <= '0;
              out_tag <= '0;
              if (count < ampq_pkg::CW'(ampq_pkg::DEPTH)) begin
                count     <= ampq_pkg::CW'(count + 1'b1);
                status    <= ampq_pkg::ST_OK;
                occupancy <= ampq_pkg::OCC_W'(count + 1'b1);
              end else begin
                status    <= ampq_pkg::ST_FULL;
                occupancy <= ampq_pkg::OCC_W'(count);
              end
            end else if (count == '0) begin
              done      <= 1'b1;
              out_key   <= '0;
              out_tag   <= '0;
              status    <= ampq_pkg::ST_EMPTY;
              occupancy <= '0;
            end else begin
              state     <= S_SCAN;
              ptr       <= ampq_pkg::CW'(1);
              cmp_idx   <= '0;
              have_best <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          best      <= best_cur;
          best_idx  <= best_idx_cur;
          have_best <= 1'b1;
          cmp_idx   <= ampq_pkg::CW'(cmp_idx + 1'b1);
          ptr       <= ampq_pkg::CW'(ptr + 1'b1);
          if (scan_last) begin
            if (best_idx_cur == count_m1) begin
              // minimum is the last entry, nothing to move
              state     <= S_IDLE;
              done      <= 1'b1;
              out_key   <= best_cur.key;
              out_tag   <= best_cur.tag;
              status    <= ampq_pkg::ST_OK;
              occupancy <= ampq_pkg::OCC_W'(count_m1);
              count     <= count_m1;
            end else begin
              state <= S_SHIFT_PRE;
            end
          end
        end
        S_SHIFT_PRE: begin
          state  <= S_SHIFT;
          mv_idx <= best_idx;
        end
        S_SHIFT: begin
          mv_idx <= ampq_pkg::CW'(mv_idx + 1'b1);
          if (ampq_pkg::CW'(mv_idx + 2'd2) >= count) begin
            state     <= S_IDLE;
            done      <= 1'b1;
            out_key   <= best.key;
            out_tag   <= best.tag;
            status    <= ampq_pkg::ST_OK;
            occupancy <= ampq_pkg::OCC_W'(count_m1);
            count     <= count_m1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // every taken item either answers next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("item taken but neither result nor busy followed");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ampq_pkg::CW'(ampq_pkg::DEPTH))
    else $error("entry count above depth");

  // a pop in progress always has at least one entry to remove
  a_busy_nonempty: assert property (@(posedge clk) disable iff (rst)
    busy |-> (count != '0))
    else $error("pop in progress on an empty queue");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (cmp_idx < count))
    else $error("scan ran past the stored entries");
`endif

endmodule

// ----- test/tb_top.sv -----
// testbench for array_min_priority_queue: a directed table, then random push/pop traffic,
// with every result checked against a behavioral copy of the queue
// depends on ampq_pkg and array_min_priority_queue
`timescale 1ns / 1ps

module tb_top;
  import ampq_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 12;
  localparam int MAX_GAP       = 17;
  // leave room past the longest pop
  localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 103;

  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
    status_t                 st;
    logic [OCC_W-1:0]        occ;
  } result_t;

  // one line of the directed table; reps > 1 repeats the item with tag counting up
  typedef struct {
    logic                    kind;
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
    int                      reps;
    bit                      given;
    result_t                 res;
  } script_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    kind = KIND_PUSH;
  logic signed [KEY_W-1:0] key = '0;
  logic [TAG_W-1:0]        tag = '0;
  logic                    busy;
  logic                    done;
  logic signed [KEY_W-1:0] out_key;
  logic [TAG_W-1:0]        out_tag;
  logic [1:0]              status;
  logic [OCC_W-1:0]        occupancy;

  // shadow copy of the queue contents
  logic signed [KEY_W-1:0] held_keys [DEPTH];
  logic [TAG_W-1:0]        held_tags [DEPTH];
  int                      held_count = 0;

  result_t     pending_results[$];
  script_row_t script[$];
  int          mismatch_count = 0;
  int          stall_cycles = 0;

  array_min_priority_queue dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .kind      (kind),
    .key       (key),
    .tag       (tag),
    .done      (done),
    .out_key   (out_key),
    .out_tag   (out_tag),
    .status    (status),
    .occupancy (occupancy)
  );

  always #HALF_PERIOD clk = ~clk;

  // apply one item to the shadow queue and return the result it should give
  function automatic result_t apply_item(input logic k, input logic signed [KEY_W-1:0] ky,
                                         input logic [TAG_W-1:0] tg);
    result_t r;
    int      best;
    r.key = '0;
    r.tag = '0;
    r.st  = ST_OK;
    if (k == KIND_PUSH) begin
      if (held_count == DEPTH) begin
        r.st = ST_FULL;
      end else begin
        held_keys[held_count] = ky;
        held_tags[held_count] = tg;
        held_count++;
      end
    end else if (held_count == 0) begin
      r.st = ST_EMPTY;
    end else begin
      // strict less-than keeps the oldest entry on equal keys
      best = 0;
      for (int i = 1; i < held_count; i++)
        if (held_keys[i] < held_keys[best]) best = i;
      r.key = held_keys[best];
      r.tag = held_tags[best];
      for (int i = best; i < held_count - 1; i++) begin
        held_keys[i] = held_keys[i + 1];
        held_tags[i] = held_tags[i + 1];
      end
      held_count--;
    end
    r.occ = OCC_W'(held_count);
    return r;
  endfunction

  function automatic void add_row(input logic k, input logic signed [KEY_W-1:0] ky,
                                  input logic [TAG_W-1:0] tg, input int reps, input bit given,
                                  input logic signed [KEY_W-1:0] want_key,
                                  input logic [TAG_W-1:0] want_tag, input status_t want_st,
                                  input int want_occ);
    script_row_t row;
    row.kind    = k;
    row.key     = ky;
    row.tag     = tg;
    row.reps    = reps;
    row.given   = given;
    row.res.key = want_key;
    row.res.tag = want_tag;
    row.res.st  = want_st;
    row.res.occ = OCC_W'(want_occ);
    script.insert(script.size(), row);
  endfunction

  // keys lean toward the extremes and a narrow band around zero so ties are common
  function automatic logic signed [KEY_W-1:0] draw_key();
    case ($urandom_range(0, 9))
      0:       return KEY_MIN;
      1:       return KEY_MAX;
      2, 3, 4: return $signed($urandom_range(0, 6)) - 3;
      default: return $urandom;
    endcase
  endfunction

  // wait gap cycles with start low, present the item, hold it until taken,
  // then queue what should come back; start stays high for a back-to-back item
  task automatic send_item(input logic k, input logic signed [KEY_W-1:0] ky,
                           input logic [TAG_W-1:0] tg, input int gap,
                           input bit given, input result_t typed);
    result_t predicted;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    kind  <= k;
    key   <= ky;
    tag   <= tg;
    do @(posedge clk); while (busy);
    predicted = apply_item(k, ky, tg);
    pending_results.insert(pending_results.size(), given ? typed : predicted);
  endtask

  // hold off new items until every outstanding result has come back
  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic report_field(input string name, input logic [KEY_W-1:0] want,
                              input logic [KEY_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // results cannot be held off, so each done cycle is checked right at its edge
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual key %h tag %h status %0d occ %0d",
                 $time, out_key, out_tag, status, occupancy);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        report_field("out_key", want.key, out_key);
        report_field("out_tag", KEY_W'(want.tag), KEY_W'(out_tag));
        report_field("status", KEY_W'(want.st), KEY_W'(status));
        report_field("occupancy", KEY_W'(want.occ), KEY_W'(occupancy));
      end
    end
  end

  // watchdog: too long without an item taken or a result given
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int      push_pct;
    bit      no_idle;
    result_t unused;
    unused = '0;

    // pop straight after reset finds the queue empty
    add_row(KIND_POP, 0, 16'h0000, 1, 1, 0, 16'h0000, ST_EMPTY, 0);
    // extremes of key and tag, alternating bit patterns, a duplicate key
    add_row(KIND_PUSH, KEY_MIN, 16'h0000, 1, 1, 0, 16'h0000, ST_OK, 1);
    add_row(KIND_PUSH, KEY_MAX, 16'hffff, 1, 1, 0, 16'h0000, ST_OK, 2);
    add_row(KIND_PUSH, 32'shaaaaaaaa, 16'haaaa, 1, 1, 0, 16'h0000, ST_OK, 3);
    add_row(KIND_PUSH, 32'sh55555555, 16'h5555, 1, 1, 0, 16'h0000, ST_OK, 4);
    add_row(KIND_PUSH, -1, 16'h0001, 1, 1, 0, 16'h0000, ST_OK, 5);
    add_row(KIND_PUSH, -1, 16'h0002, 1, 0, 0, 16'h0000, ST_OK, 0);
    // minimum at the front, then one in the middle
    add_row(KIND_POP, 0, 16'h0000, 1, 1, KEY_MIN, 16'h0000, ST_OK, 5);
    add_row(KIND_POP, 0, 16'h0000, 1, 1, 32'shaaaaaaaa, 16'haaaa, ST_OK, 4);
    // equal keys: the older entry goes first
    add_row(KIND_POP, 0, 16'h0000, 1, 0, 0, 16'h0000, ST_OK, 0);
    // fill with equal keys, then put the minimum in the last slot
    add_row(KIND_PUSH, 5, 16'h0100, 12, 0, 0, 16'h0000, ST_OK, 0);
    add_row(KIND_PUSH, KEY_MIN, 16'h0003, 1, 1, 0, 16'h0000, ST_OK, DEPTH);
    // push on a full queue is refused
    add_row(KIND_PUSH, 7, 16'h0bad, 1, 1, 0, 16'h0000, ST_FULL, DEPTH);
    // pop from full with the minimum in the last position
    add_row(KIND_POP, 0, 16'h0000, 1, 1, KEY_MIN, 16'h0003, ST_OK, DEPTH - 1);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[r])
      for (int i = 0; i < script[r].reps; i++)
        send_item(script[r].kind, script[r].key, TAG_W'(script[r].tag + i),
                  $urandom_range(0, MAX_GAP), script[r].given, script[r].res);
    wait_for_results();

    // random phases sweep the fill level: push-heavy, pop-heavy, balanced, mixed;
    // every third phase runs with no gaps between items
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0:       push_pct = 85;
        1:       push_pct = 15;
        2:       push_pct = 50;
        default: push_pct = $urandom_range(30, 70);
      endcase
      no_idle = (p % 3 == 1);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_item(($urandom_range(1, 100) <= push_pct) ? KIND_PUSH : KIND_POP, draw_key(),
                  TAG_W'($urandom), no_idle ? 0 : $urandom_range(0, MAX_GAP), 1'b0, unused);
      // let the queue go quiet between phases
      wait_for_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/ampq_pkg.sv
hw/rtl/array_min_priority_queue.sv
test/tb_top.sv
